// File: design/ttu_pkg.sv
// Shared types, widths and helpers for the triangle tangent unit.
// No dependencies; used by ttu_mul, triangle_tangent_unit and its testbench.
package ttu_pkg;

  localparam int COORD_W = 32;  // input coordinate width
  localparam int DELTA_W = 33;  // difference of two coordinates
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int ACC_W   = PROD_W + 2;  // signed sum of two products
  localparam int MAG_W   = ACC_W - 1;   // magnitude register for normalizing
  localparam int NORM_W  = 30;          // normalized component width
  localparam int SUM_W   = 2 * NORM_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int QUO_W   = 15;          // quotient bits, result never above 2^14
  localparam int OUT_W   = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DET = 2'd1,
    STATUS_ZERO_LEN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_NORM,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_STORE
  } state_t;

  // Magnitude of a signed delta; the most negative value maps to 2^32.
  function automatic logic [DELTA_W-1:0] mag_delta(logic signed [DELTA_W-1:0] v);
    mag_delta = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

endpackage

// File: design/ttu_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on ttu_pkg for the default operand width.
module ttu_mul #(
  parameter int OP_W = ttu_pkg::DELTA_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   a,
  input  logic [OP_W-1:0]   b,
  output logic              done,
  output logic [2*OP_W-1:0] prod
);
  localparam int CNT_W = $clog2(OP_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [OP_W-1:0]  mcand;
  logic [OP_W:0]    part;

  // add the multiplicand into the upper half when the low bit is set
  assign part = {1'b0, prod[2*OP_W-1:OP_W]} + (prod[0] ? {1'b0, mcand} : '0);

  // control: count the multiplier bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OP_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the partial product right one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      prod  <= {{OP_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {part, prod[OP_W-1:1]};
    end
  end

endmodule

// File: design/triangle_tangent_unit.sv
// Triangle tangent unit: three vertex requests in, one unit tangent out.
// Vertices one and two are stored in registers. The third starts the serial
// products (eight 33-bit products in ttu_mul); a zero determinant or tangent
// ends there, else a normalize shift, three squares, a square root and three
// divides follow. Reset clears the vertex slot, FSM and output valid.
module triangle_tangent_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ttu_pkg::COORD_W-1:0] pos_x,
  input  logic signed [ttu_pkg::COORD_W-1:0] pos_y,
  input  logic signed [ttu_pkg::COORD_W-1:0] pos_z,
  input  logic signed [ttu_pkg::COORD_W-1:0] tex_u,
  input  logic signed [ttu_pkg::COORD_W-1:0] tex_v,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ttu_pkg::OUT_W-1:0] tangent_x,
  output logic signed [ttu_pkg::OUT_W-1:0] tangent_y,
  output logic signed [ttu_pkg::OUT_W-1:0] tangent_z,
  output logic [1:0]                   status
);
  import ttu_pkg::*;

  state_t state, state_next;
  logic [1:0] slot;

  logic signed [COORD_W-1:0] p0 [3];
  logic signed [COORD_W-1:0] p1 [3];
  logic signed [COORD_W-1:0] uv0 [2];
  logic signed [COORD_W-1:0] uv1 [2];
  logic signed [COORD_W-1:0] p2 [3];

  logic signed [DELTA_W-1:0] e1 [3];
  logic signed [DELTA_W-1:0] e2 [3];
  logic signed [DELTA_W-1:0] du1, dv1, du2, dv2;

  logic signed [ACC_W-1:0] det;
  logic signed [ACC_W-1:0] tacc [3];
  logic [2:0]        step;
  logic [1:0]        mc;
  logic [MAG_W-1:0]  m [3];
  logic [MAG_W-1:0]  m_or;
  logic [2:0]        tneg;
  logic              det_neg;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+3:0] rem_t;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W-1:0] root;
  logic [4:0]        itr;
  logic [1:0]        cidx;
  logic [ROOT_W:0]   divisor;
  logic [ROOT_W:0]   drem;
  logic [ROOT_W+1:0] dr_t;
  logic [QUO_W-1:0]  dnum;
  logic [QUO_W-1:0]  quo;
  logic [NORM_W+QUO_W:0] numer;
  logic signed [OUT_W-1:0] tan [3];
  logic signed [OUT_W-1:0] qval;

  logic in_take;
  logic sq_phase;
  logic mul_start, mul_done;
  logic signed [DELTA_W-1:0] mx, my;
  logic [NORM_W-1:0]  nsel;
  logic [DELTA_W-1:0] op_a, op_b;
  logic [PROD_W-1:0]  mul_prod;
  logic [ACC_W-1:0]   pext;
  logic signed [ACC_W-1:0] term;

  assign p2[0] = pos_x;
  assign p2[1] = pos_y;
  assign p2[2] = pos_z;
  assign in_take = in_valid && in_ready;

  // pick product operands: determinant terms first, then tangent terms
  always_comb begin
    mc = 2'(step[2:1] - 2'd1);
    if (step < 3'd2) begin
      mx = step[0] ? du2 : du1;
      my = step[0] ? dv1 : dv2;
    end else begin
      mx = step[0] ? dv1 : dv2;
      my = step[0] ? e2[mc] : e1[mc];
    end
  end

  assign sq_phase = (state == ST_SQ_START) || (state == ST_SQ_WAIT);
  assign nsel = m[step[1:0]][MAG_W-1 -: NORM_W];
  assign op_a = sq_phase ? DELTA_W'(nsel) : mag_delta(mx);
  assign op_b = sq_phase ? DELTA_W'(nsel) : mag_delta(my);
  assign pext = {2'b00, mul_prod};
  assign term = ((mx[DELTA_W-1] ^ my[DELTA_W-1]) ^ step[0]) ? -$signed(pext)
                                                            : $signed(pext);

  ttu_mul #(.OP_W(DELTA_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // normalize, root and divide helpers
  assign m_or  = m[0] | m[1] | m[2];
  assign rem_t = {rem, rad[SUM_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign dr_t  = {drem, dnum[QUO_W-1]};
  assign numer = {1'b0, m[cidx][MAG_W-1 -: NORM_W], {QUO_W{1'b0}}} + (NORM_W+QUO_W+1)'(root);
  assign qval  = (tneg[cidx] ^ det_neg) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !(slot[1] && out_valid);
        if (in_take && slot[1]) state_next = ST_MUL_START;
      end
      ST_MUL_START: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) state_next = (step == 3'd7) ? ST_CHECK : ST_MUL_START;
      end
      ST_CHECK: begin
        if (det == '0 || (tacc[0] == '0 && tacc[1] == '0 && tacc[2] == '0))
          state_next = ST_IDLE;
        else
          state_next = ST_NORM;
      end
      ST_NORM: begin
        if (m_or[MAG_W-1]) state_next = ST_SQ_START;
      end
      ST_SQ_START: begin
        mul_start  = 1'b1;
        state_next = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_done) state_next = (step == 3'd2) ? ST_ROOT_LOAD : ST_SQ_START;
      end
      ST_ROOT_LOAD: state_next = ST_ROOT;
      ST_ROOT: begin
        if (itr == 5'd1) state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (itr == 5'd1) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        state_next = (cidx == 2'd2) ? ST_IDLE : ST_DIV_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control: vertex slot and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) slot <= slot[1] ? 2'd0 : slot + 2'd1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((state == ST_CHECK && state_next == ST_IDLE) ||
          (state == ST_DIV_STORE && cidx == 2'd2))
        out_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          priority case (slot)
            2'd0: begin
              p0[0] <= pos_x; p0[1] <= pos_y; p0[2] <= pos_z;
              uv0[0] <= tex_u; uv0[1] <= tex_v;
            end
            2'd1: begin
              p1[0] <= pos_x; p1[1] <= pos_y; p1[2] <= pos_z;
              uv1[0] <= tex_u; uv1[1] <= tex_v;
            end
            default: begin
              // third vertex: form edges and UV deltas
              for (int c = 0; c < 3; c++) begin
                e1[c]   <= DELTA_W'(p1[c]) - DELTA_W'(p0[c]);
                e2[c]   <= DELTA_W'(p2[c]) - DELTA_W'(p0[c]);
                tacc[c] <= '0;
              end
              du1  <= DELTA_W'(uv1[0]) - DELTA_W'(uv0[0]);
              dv1  <= DELTA_W'(uv1[1]) - DELTA_W'(uv0[1]);
              du2  <= DELTA_W'(tex_u) - DELTA_W'(uv0[0]);
              dv2  <= DELTA_W'(tex_v) - DELTA_W'(uv0[1]);
              det  <= '0;
              step <= 3'd0;
            end
          endcase
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (step < 3'd2) det <= det + term;
          else tacc[mc] <= tacc[mc] + term;
          step <= step + 3'd1;
        end
      end
      ST_CHECK: begin
        for (int c = 0; c < 3; c++) begin
          m[c]    <= MAG_W'(tacc[c][ACC_W-1] ? -tacc[c] : tacc[c]);
          tneg[c] <= tacc[c][ACC_W-1];
          tan[c]  <= '0;
        end
        det_neg <= det[ACC_W-1];
        if (det == '0) status <= STATUS_ZERO_DET;
        else status <= STATUS_ZERO_LEN;
      end
      ST_NORM: begin
        // shift all three until the largest has its top bit set
        if (!m_or[MAG_W-1]) begin
          for (int c = 0; c < 3; c++) m[c] <= {m[c][MAG_W-2:0], 1'b0};
        end
        step <= 3'd0;
        sum  <= '0;
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          sum  <= sum + mul_prod[SUM_W-1:0];
          step <= step + 3'd1;
        end
      end
      ST_ROOT_LOAD: begin
        rad  <= sum;
        rem  <= '0;
        root <= '0;
        itr  <= 5'(ROOT_W);
      end
      ST_ROOT: begin
        // one result bit per cycle, two radicand bits in
        if (rem_t >= {2'b00, trial}) begin
          rem  <= (ROOT_W+2)'(rem_t - {2'b00, trial});
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= (ROOT_W+2)'(rem_t);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        rad  <= {rad[SUM_W-3:0], 2'b00};
        itr  <= itr - 5'd1;
        cidx <= 2'd0;
      end
      ST_DIV_LOAD: begin
        divisor <= {root, 1'b0};
        drem    <= (ROOT_W+1)'(numer[NORM_W+QUO_W:QUO_W]);
        dnum    <= numer[QUO_W-1:0];
        itr     <= 5'(QUO_W);
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (dr_t >= {1'b0, divisor}) begin
          drem <= (ROOT_W+1)'(dr_t - {1'b0, divisor});
          quo  <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          drem <= (ROOT_W+1)'(dr_t);
          quo  <= {quo[QUO_W-2:0], 1'b0};
        end
        dnum <= {dnum[QUO_W-2:0], 1'b0};
        itr  <= itr - 5'd1;
      end
      ST_DIV_STORE: begin
        tan[cidx] <= qval;
        cidx      <= cidx + 2'd1;
        status    <= STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  assign tangent_x = tan[0];
  assign tangent_y = tan[1];
  assign tangent_z = tan[2];

  // a flagged result carries a zero tangent
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> tangent_x == '0 && tangent_y == '0 && tangent_z == '0)
    else $error("flagged result with nonzero tangent");

  // no vertex is taken while a triangle is in work
  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("request accepted while busy");

  // the vertex slot never reaches three
  assert property (@(posedge clk) disable iff (rst) slot != 2'd3)
    else $error("vertex slot out of range");

  // a product only completes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL_WAIT || state == ST_SQ_WAIT)
    else $error("unexpected multiplier completion");

endmodule

// File: test/triangle_tangent_unit_test.sv
// Self-checking testbench for triangle_tangent_unit: vertex requests in, unit tangents out.
// Depends on ttu_pkg (status_t and its status codes) and the triangle_tangent_unit RTL only.
module triangle_tangent_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ttu_pkg::*;

  typedef struct packed {
    logic signed [31:0] px, py, pz, u, v;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] tx, ty, tz;
    status_t            st;
  } tangent_t;

  typedef struct packed {
    vertex_t  vx;
    bit       typed;  // expected result written in the row
    tangent_t res;
  } stim_row_t;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE   = 32'sh0001_0000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic [1:0] status;

  triangle_tangent_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .status(status)
  );

  // Predictor state: two held vertices and the slot of the next one
  logic signed [31:0] held_pos [6];
  logic signed [31:0] held_tex [4];
  int unsigned        next_slot;

  tangent_t pending_tangents [$];
  bit       typed_pending [$];
  int       sender_idle_pct, receiver_stall_pct;
  bit       failed;
  int       cycle_count;

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the vertex slot; on the third vertex compute the unit tangent
  function automatic bit tangent_for(vertex_t vx, output tangent_t res);
    logic signed [31:0] p2 [3];
    logic signed [32:0] e1, e2, du1, dv1, du2, dv2;
    logic signed [69:0] det;
    logic signed [69:0] tv [3];
    logic [69:0] m [3];
    logic [63:0] n [3];
    logic [63:0] sum, r, q;
    int len;
    bit neg;
    res = '0;
    p2[0] = vx.px; p2[1] = vx.py; p2[2] = vx.pz;
    if (next_slot < 2) begin
      for (int c = 0; c < 3; c++) held_pos[next_slot*3 + c] = p2[c];
      held_tex[next_slot*2] = vx.u;
      held_tex[next_slot*2 + 1] = vx.v;
      next_slot++;
      return 1'b0;
    end
    next_slot = 0;
    du1 = held_tex[2] - held_tex[0];
    dv1 = held_tex[3] - held_tex[1];
    du2 = vx.u - held_tex[0];
    dv2 = vx.v - held_tex[1];
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      res.st = STATUS_ZERO_DET;
      return 1'b1;
    end
    len = 0;
    for (int c = 0; c < 3; c++) begin
      e1 = held_pos[3 + c] - held_pos[c];
      e2 = p2[c] - held_pos[c];
      tv[c] = dv2 * e1 - dv1 * e2;
      m[c] = tv[c] < 0 ? 70'(-tv[c]) : 70'(tv[c]);
      for (int b = 69; b >= 0; b--) begin
        if (m[c][b]) begin
          if (b + 1 > len) len = b + 1;
          break;
        end
      end
    end
    if (len == 0) begin
      res.st = STATUS_ZERO_LEN;
      return 1'b1;
    end
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      n[c] = len < 30 ? 64'(m[c] << (30 - len)) : 64'(m[c] >> (len - 30));
      sum = sum + n[c] * n[c];
    end
    r = int_sqrt(sum);
    for (int c = 0; c < 3; c++) begin
      q = (n[c] * 64'd32768 + r) / (64'd2 * r);
      neg = (tv[c] < 0) != (det < 0);
      if (c == 0) res.tx = neg ? -q[15:0] : q[15:0];
      if (c == 1) res.ty = neg ? -q[15:0] : q[15:0];
      if (c == 2) res.tz = neg ? -q[15:0] : q[15:0];
    end
    res.st = STATUS_OK;
    return 1'b1;
  endfunction

  // Drive one vertex request, idling first at the current rate
  task automatic send_vertex(vertex_t vx, bit typed, tangent_t typed_res);
    tangent_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= vx.px; pos_y <= vx.py; pos_z <= vx.pz;
    tex_u <= vx.u;  tex_v <= vx.v;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (tangent_for(vx, predicted)) begin
      if (typed && predicted != typed_res) begin
        $error("typed row disagrees with predictor: %h vs %h", typed_res, predicted);
        failed = 1'b1;
      end
      pending_tangents = {pending_tangents, (typed ? typed_res : predicted)};
      typed_pending = {typed_pending, typed};
    end
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed(32'($urandom_range(8 * 65536))) - 4 * 65536;
      2: return $urandom_range(1) ? S_MAX : S_MIN;
      default: return $signed(32'($urandom_range(15))) - 8;
    endcase
  endfunction

  // Send one random triangle; some share UVs or positions to hit the degenerate cases
  task automatic send_random_triangle();
    vertex_t verts [3];
    tangent_t none;
    int mode, flavor;
    none = '0;
    mode = $urandom_range(3);
    flavor = $urandom_range(9);
    for (int k = 0; k < 3; k++) begin
      verts[k].px = rand_coord(mode); verts[k].py = rand_coord(mode);
      verts[k].pz = rand_coord(mode); verts[k].u = rand_coord(mode);
      verts[k].v = rand_coord(mode);
    end
    if (flavor == 0) begin
      verts[2].u = verts[0].u; verts[2].v = verts[0].v;
    end else if (flavor == 1) begin
      verts[1].px = verts[0].px; verts[1].py = verts[0].py; verts[1].pz = verts[0].pz;
      verts[2].px = verts[0].px; verts[2].py = verts[0].py; verts[2].pz = verts[0].pz;
    end
    for (int k = 0; k < 3; k++) send_vertex(verts[k], 1'b0, none);
  endtask

  // Stall the receiver at the current rate
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check each accepted tangent against the oldest expectation
  initial begin
    tangent_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_tangents.size() == 0) begin
          $error("unexpected result: %0d %0d %0d status %0d",
                 tangent_x, tangent_y, tangent_z, status);
          failed = 1'b1;
        end else begin
          want = pending_tangents.pop_front();
          void'(typed_pending.pop_front());
          if (tangent_x !== want.tx) begin
            $error("tangent_x expected %0d got %0d", want.tx, tangent_x);
            failed = 1'b1;
          end
          if (tangent_y !== want.ty) begin
            $error("tangent_y expected %0d got %0d", want.ty, tangent_y);
            failed = 1'b1;
          end
          if (tangent_z !== want.tz) begin
            $error("tangent_z expected %0d got %0d", want.tz, tangent_z);
            failed = 1'b1;
          end
          if (status !== want.st) begin
            $error("status expected %0d got %0d", want.st, status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Drop the run if it hangs
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("triangle_tangent_unit_test: errors");
        $finish;
      end
    end
  end

  // Directed table, then random triangles across the idle and stall phases
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    tangent_t  none;
    int idle_tab  [4];
    int stall_tab [4];
    none = '0;
    idle_tab  = '{0, 80, 0, 17};
    stall_tab = '{0, 0, 80, 17};
    failed = 1'b0;
    next_slot = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0; tex_u = '0; tex_v = '0;

    // All zero: zero determinant
    row = '0; rows = {rows, row}; rows = {rows, row};
    row.typed = 1'b1; row.res = '{16'sd0, 16'sd0, 16'sd0, STATUS_ZERO_DET};
    rows = {rows, row};
    // Unit axis triangle, positive determinant: tangent along +x
    row = '0; rows = {rows, row};
    row.vx = '{ONE, 0, 0, ONE, 0}; rows = {rows, row};
    row.vx = '{0, ONE, 0, 0, ONE}; row.typed = 1'b1;
    row.res = '{16'sd16384, 16'sd0, 16'sd0, STATUS_OK}; rows = {rows, row};
    // Negative determinant flips the tangent
    row = '0; rows = {rows, row};
    row.vx = '{ONE, 0, 0, -ONE, 0}; rows = {rows, row};
    row.vx = '{0, ONE, 0, 0, ONE}; row.typed = 1'b1;
    row.res = '{-16'sd16384, 16'sd0, 16'sd0, STATUS_OK}; rows = {rows, row};
    // Coincident positions with valid UVs: zero-length tangent
    row = '0; row.vx = '{S_MAX, S_MIN, ONE, 0, 0}; rows = {rows, row};
    row.vx.u = ONE; rows = {rows, row};
    row.vx.u = 0; row.vx.v = ONE; row.typed = 1'b1;
    row.res = '{16'sd0, 16'sd0, 16'sd0, STATUS_ZERO_LEN}; rows = {rows, row};
    // Extreme positions and UVs: widest deltas and products
    row = '0; row.vx = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}; rows = {rows, row};
    row.vx = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MIN}; rows = {rows, row};
    row.vx = '{S_MIN, S_MAX, S_MIN, S_MIN, S_MAX}; rows = {rows, row};
    // Alternating bit patterns
    row.vx = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    rows = {rows, row};
    row.vx = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001};
    rows = {rows, row};
    row.vx = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0003, 32'hAAAA_AAAA};
    rows = {rows, row};
    // Tiny deltas: short tangent, shifted up to full precision
    row.vx = '{0, 0, 0, 0, 0}; rows = {rows, row};
    row.vx = '{1, 2, -3, 1, 0}; rows = {rows, row};
    row.vx = '{-1, 1, 1, 0, 1}; rows = {rows, row};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_vertex(rows[i].vx, rows[i].typed, rows[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_tab[ph];
      receiver_stall_pct = stall_tab[ph];
      for (int t = 0; t < 91; t++) send_random_triangle();
    end
    in_valid <= 1'b0;

    while (pending_tangents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("triangle_tangent_unit_test: clean");
    end else begin
      $display("triangle_tangent_unit_test: errors");
    end
    $finish;
  end

endmodule
